[sv/dett_pkg.sv]
package dett_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned DELAY_W  = 32;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned WORD_W   = DELAY_W + HANDLE_W;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_TICK     = 2'd2,
    OP_UNUSED   = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_FULL     = 2'd1,
    KIND_FIRED    = 2'd2,
    KIND_IDLE     = 2'd3
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input item and clear the walk flags
    logic rd;          // read the slot at the current index
    logic inc_idx;     // step to the next slot
    logic wr_new;      // write delay and handle of the item into the slot
    logic wr_clear;    // write an empty slot
    logic wr_dec;      // write the slot back with its count decremented
    logic set_found;   // a free slot was taken
    logic set_others;  // another slot still holds a nonzero handle
    logic set_active;  // a slot was counted down
    logic take_pend;   // hold the handle of the slot that just fired
    logic push_pend;   // send the held fired handle as a non-final result
    logic push_final;  // send the final result of the item
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic running;
    logic rem_zero;
    logic hdl_zero;
    logic hdl_match;
    logic dec_zero;
    logic idx_last;
    logic out_free;
    logic pend_valid;
  } sts_t;

endpackage

[sv/dett_if.sv]
interface dett_in_if;
  logic                             valid;
  logic                             ready;
  logic [dett_pkg::OP_W-1:0]        op;
  logic [dett_pkg::DELAY_W-1:0]     delay_ms;
  logic [dett_pkg::HANDLE_W-1:0]    handle;

  modport source (output valid, output op, output delay_ms, output handle, input ready);
  modport sink   (input valid, input op, input delay_ms, input handle, output ready);
endinterface

interface dett_out_if;
  logic                             valid;
  logic                             ready;
  logic [dett_pkg::KIND_W-1:0]      kind;
  logic [dett_pkg::HANDLE_W-1:0]    fired_handle;
  logic                             last;
  logic                             tick_running;

  modport source (output valid, output kind, output fired_handle, output last,
                  output tick_running, input ready);
  modport sink   (input valid, input kind, input fired_handle, input last,
                  input tick_running, output ready);
endinterface

[sv/dett_ram.sv]
module dett_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/dett_datapath.sv]
module dett_datapath #(
  parameter int unsigned SLOTS = 8,
  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dett_pkg::cmd_t                cmd_i,
  output dett_pkg::sts_t                sts_o,
  input  logic [dett_pkg::OP_W-1:0]     in_op_i,
  input  logic [dett_pkg::DELAY_W-1:0]  in_delay_i,
  input  logic [dett_pkg::HANDLE_W-1:0] in_handle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dett_pkg::KIND_W-1:0]   out_kind_o,
  output logic [dett_pkg::HANDLE_W-1:0] out_handle_o,
  output logic                          out_last_o,
  output logic                          out_running_o
);

  localparam int unsigned DW = dett_pkg::DELAY_W;
  localparam int unsigned HW = dett_pkg::HANDLE_W;

  dett_pkg::op_e   op_q;
  logic [DW-1:0]   delay_q;
  logic [HW-1:0]   handle_q;
  logic            running_q, running_d;
  logic            found_q, others_q, active_q;
  logic            pend_valid_q;
  logic [HW-1:0]   pend_q;
  logic [IW-1:0]   idx_q;
  logic            rd_valid_q;
  logic [SLOTS-1:0] valid_q;

  logic                      out_valid_q;
  logic [dett_pkg::KIND_W-1:0] out_kind_q;
  logic [HW-1:0]             out_handle_q;
  logic                      out_last_q;
  logic                      out_running_q;

  logic [dett_pkg::WORD_W-1:0] rdata;
  logic [dett_pkg::WORD_W-1:0] wdata;
  logic                        we;
  logic [DW-1:0]               rem_r;
  logic [HW-1:0]               hdl_r;
  logic                        out_free;

  dett_pkg::kind_e final_kind;
  logic [HW-1:0]   final_handle;

  dett_ram #(
    .WIDTH (dett_pkg::WORD_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (idx_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // A slot that was never written reads as empty.
  assign rem_r = rd_valid_q ? rdata[DW-1:0] : '0;
  assign hdl_r = rd_valid_q ? rdata[dett_pkg::WORD_W-1:DW] : '0;

  assign we = cmd_i.wr_new | cmd_i.wr_clear | cmd_i.wr_dec;

  always_comb begin
    if (cmd_i.wr_new) begin
      wdata = {handle_q, delay_q};
    end else if (cmd_i.wr_dec) begin
      wdata = {hdl_r, rem_r - DW'(1)};
    end else begin
      wdata = '0;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    final_kind   = dett_pkg::KIND_ACCEPTED;
    final_handle = '0;
    running_d    = running_q;
    case (op_q)
      dett_pkg::OP_REGISTER: begin
        final_kind = found_q ? dett_pkg::KIND_ACCEPTED : dett_pkg::KIND_FULL;
        if (found_q) begin
          running_d = 1'b1;
        end
      end
      dett_pkg::OP_REMOVE: begin
        if (!others_q) begin
          running_d = 1'b0;
        end
      end
      dett_pkg::OP_TICK: begin
        if (pend_valid_q) begin
          final_kind   = dett_pkg::KIND_FIRED;
          final_handle = pend_q;
        end else begin
          final_kind = dett_pkg::KIND_IDLE;
        end
        if (!active_q) begin
          running_d = 1'b0;
        end
      end
      default: begin
        final_kind = dett_pkg::KIND_ACCEPTED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      found_q      <= 1'b0;
      others_q     <= 1'b0;
      active_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      idx_q        <= '0;
      rd_valid_q   <= 1'b0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        found_q      <= 1'b0;
        others_q     <= 1'b0;
        active_q     <= 1'b0;
        pend_valid_q <= 1'b0;
        idx_q        <= '0;
      end
      if (cmd_i.inc_idx) begin
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.rd) begin
        rd_valid_q <= valid_q[idx_q];
      end
      if (we) begin
        valid_q[idx_q] <= 1'b1;
      end
      if (cmd_i.set_found) begin
        found_q <= 1'b1;
      end
      if (cmd_i.set_others) begin
        others_q <= 1'b1;
      end
      if (cmd_i.set_active) begin
        active_q <= 1'b1;
      end
      if (cmd_i.take_pend) begin
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.push_final) begin
        running_q <= running_d;
      end
      if (cmd_i.push_pend || cmd_i.push_final) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= dett_pkg::op_e'(in_op_i);
      delay_q  <= in_delay_i;
      handle_q <= in_handle_i;
    end
    if (cmd_i.take_pend) begin
      pend_q <= hdl_r;
    end
    if (cmd_i.push_pend) begin
      out_kind_q    <= dett_pkg::KIND_FIRED;
      out_handle_q  <= pend_q;
      out_last_q    <= 1'b0;
      out_running_q <= running_q;
    end else if (cmd_i.push_final) begin
      out_kind_q    <= final_kind;
      out_handle_q  <= final_handle;
      out_last_q    <= 1'b1;
      out_running_q <= running_d;
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.running    = running_q;
  assign sts_o.rem_zero   = (rem_r == '0);
  assign sts_o.hdl_zero   = (hdl_r == '0);
  assign sts_o.hdl_match  = (hdl_r == handle_q);
  assign sts_o.dec_zero   = (rem_r == DW'(1));
  assign sts_o.idx_last   = (idx_q == IW'(SLOTS - 1));
  assign sts_o.out_free   = out_free;
  assign sts_o.pend_valid = pend_valid_q;

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_handle_o  = out_handle_q;
  assign out_last_o    = out_last_q;
  assign out_running_o = out_running_q;

endmodule

[sv/dett_ctrl.sv]
module dett_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dett_pkg::sts_t sts_i,
  output dett_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   fire;

  assign in_ready_o = (state_q == ST_IDLE);

  // The slot counts down to zero on this tick.
  assign fire = !sts_i.rem_zero && !sts_i.hdl_zero && sts_i.dec_zero;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        case (sts_i.op)
          dett_pkg::OP_REGISTER, dett_pkg::OP_REMOVE: state_d = ST_READ;
          dett_pkg::OP_TICK: state_d = sts_i.running ? ST_READ : ST_FINISH;
          default: state_d = ST_FINISH;
        endcase
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = sts_i.idx_last ? ST_FINISH : ST_READ;
        case (sts_i.op)
          dett_pkg::OP_REGISTER: begin
            if (sts_i.rem_zero) begin
              cmd_o.wr_new    = 1'b1;
              cmd_o.set_found = 1'b1;
              state_d         = ST_FINISH;
            end
          end
          dett_pkg::OP_REMOVE: begin
            if (sts_i.hdl_match) begin
              cmd_o.wr_clear = 1'b1;
            end else if (!sts_i.hdl_zero) begin
              cmd_o.set_others = 1'b1;
            end
          end
          default: begin
            if (fire && sts_i.pend_valid && !sts_i.out_free) begin
              // The earlier fired handle cannot leave yet, so hold this slot.
              state_d = ST_EVAL;
            end else if (!sts_i.rem_zero && !sts_i.hdl_zero) begin
              cmd_o.wr_dec     = 1'b1;
              cmd_o.set_active = 1'b1;
              if (fire) begin
                cmd_o.take_pend = 1'b1;
                cmd_o.push_pend = sts_i.pend_valid;
              end
            end
          end
        endcase
        if (state_d == ST_READ) begin
          cmd_o.inc_idx = 1'b1;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.push_final = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/delayed_event_timer_table_top.sv]
// Table of one-shot delay timers.
//
// Items arrive on in_i: op selects register (delay_ms and handle go into the
// lowest slot whose count is zero), remove (every slot holding handle is
// cleared) or tick (each active slot counts down once). Results leave on
// out_o, one or more per item; last marks the final result of an item and
// tick_running shows whether the tick source is enabled after the item.
// A tick reports every handle whose count reaches zero, in slot order.
//
// The block works on one item at a time. The slots live in a RAM with one
// read port and one write port that is walked slot by slot (read, then
// evaluate and write back), so a running tick or a remove visits every
// slot and a register stops at the first free slot. A stalled
// receiver holds the output register; the walk pauses while a second fired
// handle waits for the first to leave, and the final result waits as well.
// Each transfer on out_o frees the output register for the next result.
//
// Reset clears the per-slot valid bits, so every slot reads as empty, stops
// the tick source and drops any pending result. No clearing pass is needed.
module delayed_event_timer_table_top #(
  parameter int unsigned SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dett_in_if.sink           in_i,
  dett_out_if.source        out_o
);

  dett_pkg::cmd_t cmd;
  dett_pkg::sts_t sts;

  // The controller sequences the slot walk; the datapath holds the slots,
  // the walk flags and the output register.
  dett_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dett_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_op_i       (in_i.op),
    .in_delay_i    (in_i.delay_ms),
    .in_handle_i   (in_i.handle),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_kind_o    (out_o.kind),
    .out_handle_o  (out_o.fired_handle),
    .out_last_o    (out_o.last),
    .out_running_o (out_o.tick_running)
  );

endmodule

[sv/dett_checker.sv]
module dett_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [dett_pkg::KIND_W-1:0]   kind_i,
  input logic [dett_pkg::HANDLE_W-1:0] fired_handle_i,
  input logic                          last_i,
  input logic                          tick_running_i
);

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({kind_i, fired_handle_i, last_i, tick_running_i}))
    else $error("stalled result changed");

  // One item at a time: no transfer right after an accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transfer");

  // A fired result carries a real handle and the tick keeps running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == dett_pkg::KIND_FIRED |-> fired_handle_i != '0 && tick_running_i)
    else $error("fired result without handle or running tick");

  // Every other kind is the only result of its item and has no handle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != dett_pkg::KIND_FIRED |-> last_i && fired_handle_i == '0)
    else $error("non-fired result is not a lone final result");

endmodule

bind delayed_event_timer_table_top dett_checker u_dett_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .fired_handle_i (out_o.fired_handle),
  .last_i         (out_o.last),
  .tick_running_i (out_o.tick_running)
);

[tb/dett_fire_monitor.sv]
module dett_fire_monitor #(
  parameter int unsigned SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dett_in_if          in_mon,
  dett_out_if         out_mon,
  output int unsigned error_count_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    dett_pkg::kind_e                kind;
    logic [dett_pkg::HANDLE_W-1:0]  fired_handle;
    logic                           last;
    logic                           tick_running;
  } timer_result_t;

  // Shadow copy of the timer table.
  logic [dett_pkg::DELAY_W-1:0]  count_q  [SLOTS];
  logic [dett_pkg::HANDLE_W-1:0] handle_q [SLOTS];
  logic                          tick_on_q;

  timer_result_t pending_results [$];
  int unsigned   error_count;

  assign error_count_o = error_count;
  assign outstanding_o = pending_results.size();

  task automatic report_mismatch(input string msg);
    $display("%0t ns: ERROR %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void predict_timer_results(input dett_pkg::op_e op,
                                                input logic [dett_pkg::DELAY_W-1:0] delay,
                                                input logic [dett_pkg::HANDLE_W-1:0] handle);
    dett_pkg::kind_e               kinds [$];
    logic [dett_pkg::HANDLE_W-1:0] fired [$];
    logic                          found;
    logic                          others;
    logic                          active;
    timer_result_t                 res;
    found  = 1'b0;
    others = 1'b0;
    active = 1'b0;
    case (op)
      dett_pkg::OP_REGISTER: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && count_q[i] == '0) begin
            count_q[i]  = delay;
            handle_q[i] = handle;
            tick_on_q   = 1'b1;
            found       = 1'b1;
          end
        end
        kinds.push_back(found ? dett_pkg::KIND_ACCEPTED : dett_pkg::KIND_FULL);
        fired.push_back('0);
      end
      dett_pkg::OP_REMOVE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (handle_q[i] == handle) begin
            count_q[i]  = '0;
            handle_q[i] = '0;
          end else if (handle_q[i] != '0) begin
            others = 1'b1;
          end
        end
        if (!others) tick_on_q = 1'b0;
        kinds.push_back(dett_pkg::KIND_ACCEPTED);
        fired.push_back('0);
      end
      dett_pkg::OP_TICK: begin
        if (tick_on_q) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (count_q[i] != '0 && handle_q[i] != '0) begin
              active     = 1'b1;
              count_q[i] = count_q[i] - 1'b1;
              if (count_q[i] == '0) begin
                kinds.push_back(dett_pkg::KIND_FIRED);
                fired.push_back(handle_q[i]);
              end
            end
          end
          if (!active) tick_on_q = 1'b0;
        end
        if (kinds.size() == 0) begin
          kinds.push_back(dett_pkg::KIND_IDLE);
          fired.push_back('0);
        end
      end
      default: begin
        kinds.push_back(dett_pkg::KIND_ACCEPTED);
        fired.push_back('0);
      end
    endcase
    foreach (kinds[k]) begin
      res.kind         = kinds[k];
      res.fired_handle = fired[k];
      res.last         = (k == kinds.size() - 1);
      res.tick_running = tick_on_q;
      pending_results.push_back(res);
    end
  endfunction

  task automatic check_result();
    timer_result_t exp;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind=%0d handle=%0d",
                                out_mon.kind, out_mon.fired_handle));
    end else begin
      exp = pending_results.pop_front();
      if (out_mon.kind !== exp.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", out_mon.kind, exp.kind));
      if (out_mon.fired_handle !== exp.fired_handle)
        report_mismatch($sformatf("fired_handle %0d, expected %0d",
                                  out_mon.fired_handle, exp.fired_handle));
      if (out_mon.last !== exp.last)
        report_mismatch($sformatf("last %b, expected %b", out_mon.last, exp.last));
      if (out_mon.tick_running !== exp.tick_running)
        report_mismatch($sformatf("tick_running %b, expected %b",
                                  out_mon.tick_running, exp.tick_running));
    end
  endtask

  initial error_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        count_q[i]  = '0;
        handle_q[i] = '0;
      end
      tick_on_q = 1'b0;
      pending_results.delete();
    end else begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) check_result();
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        predict_timer_results(dett_pkg::op_e'(in_mon.op), in_mon.delay_ms, in_mon.handle);
    end
  end

endmodule

[tb/delayed_event_timer_table_top_test.sv]
module delayed_event_timer_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS        = 8;
  localparam int unsigned RANDOM_ITEMS = 350;
  // The limit lies above the slowest correct run: every item with
  // the longest gap, eight results each waiting out the longest stall.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // A tick or remove walks all slots; the drain allows twice that walk time.
  localparam int unsigned DRAIN_CYCLES = 4 * SLOTS + 6;

  logic        clk;
  logic        rst_n;
  bit          no_idle;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned outstanding;

  dett_in_if  in_ch ();
  dett_out_if out_ch ();

  delayed_event_timer_table_top #(
    .SLOTS (SLOTS)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // The monitor watches both channels, predicts the results of every accepted
  // item and compares them with what leaves the block.
  dett_fire_monitor #(
    .SLOTS (SLOTS)
  ) u_monitor (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .error_count_o (error_count),
    .outstanding_o (outstanding)
  );

  // 12 ns clock period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Gap lengths: mostly none or short, now and then a long one. During the
  // stretches where no_idle is set, both sides run flat out.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Handles mostly come from a small pool so that removes find their targets.
  function automatic logic [dett_pkg::HANDLE_W-1:0] pick_handle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 12) return dett_pkg::HANDLE_W'($urandom_range(0, 255));
    return dett_pkg::HANDLE_W'($urandom_range(1, 12));
  endfunction

  // Short delays keep events firing; a few huge ones occupy slots until a
  // remove frees them, which is how the table runs full.
  function automatic logic [dett_pkg::DELAY_W-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 80) return $urandom_range(1, 6);
    if (r < 88) return $urandom_range(7, 40);
    if (r < 95) return $urandom();
    return '1;
  endfunction

  // Drives one item after a random gap and holds it until the transfer.
  // Every drive happens on the falling edge, and valid gets exactly one
  // assignment per edge, so back-to-back items keep valid high throughout.
  task automatic send_item(input dett_pkg::op_e op,
                           input logic [dett_pkg::DELAY_W-1:0] delay,
                           input logic [dett_pkg::HANDLE_W-1:0] handle);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.delay_ms <= delay;
    in_ch.handle   <= handle;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // The receiver stalls in the same pattern, independent of the sender, so
  // stalls land on every phase of the slot walk and on pending fired handles.
  initial begin
    int unsigned stall;
    int unsigned burst;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = gap_len();
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      burst = $urandom_range(1, 6);
      repeat (burst - 1) @(negedge clk);
    end
  end

  initial begin
    int unsigned counted;
    int unsigned batch;
    int unsigned r;
    logic [dett_pkg::DELAY_W-1:0] batch_delay;

    in_ch.valid    = 1'b0;
    in_ch.op       = dett_pkg::OP_TICK;
    in_ch.delay_ms = '0;
    in_ch.handle   = '0;
    no_idle        = 1'b0;
    rst_n          = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A tick while the tick source is stopped, the unused
    // opcode with all field bits set, and a remove on an empty table.
    send_item(dett_pkg::OP_TICK, '0, '0);
    send_item(dett_pkg::OP_UNUSED, '1, '1);
    send_item(dett_pkg::OP_REMOVE, '0, '0);
    // One event fires on the next tick, then a tick with nothing active
    // stops the tick source.
    send_item(dett_pkg::OP_REGISTER, 32'd1, 8'd255);
    send_item(dett_pkg::OP_TICK, '0, '0);
    send_item(dett_pkg::OP_TICK, '0, '0);
    // A zero delay leaves the slot free, so the next register with handle
    // zero lands in the same slot; removing handle zero then clears it.
    send_item(dett_pkg::OP_REGISTER, '0, 8'd5);
    send_item(dett_pkg::OP_REGISTER, 32'd3, '0);
    send_item(dett_pkg::OP_REMOVE, '0, '0);
    // Fill every slot with the same delay, try one more (table full), and
    // then tick twice so that all eight handles fire on one tick.
    for (int unsigned i = 1; i <= SLOTS; i++) send_item(dett_pkg::OP_REGISTER, 32'd2, 8'(i));
    send_item(dett_pkg::OP_REGISTER, '1, 8'd9);
    send_item(dett_pkg::OP_TICK, '0, '0);
    send_item(dett_pkg::OP_TICK, '0, '0);
    // The largest delay, then its removal while other handles remain.
    send_item(dett_pkg::OP_REGISTER, '1, 8'hAA);
    send_item(dett_pkg::OP_REMOVE, '0, 8'hAA);
    send_item(dett_pkg::OP_TICK, '0, '0);

    // Random part. Most iterations are single items; some are well-formed
    // batches that register several events with one delay and then tick
    // until they fire together. The unused opcode is not counted.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      no_idle = ((counted / 50) % 4) == 3;
      r = $urandom_range(0, 99);
      if (r < 15) begin
        batch       = $urandom_range(1, SLOTS);
        batch_delay = $urandom_range(1, 3);
        repeat (batch) send_item(dett_pkg::OP_REGISTER, batch_delay, pick_handle());
        repeat (batch_delay)
          send_item(dett_pkg::OP_TICK, $urandom(), 8'($urandom_range(0, 255)));
        counted += batch + batch_delay;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 38) begin
          send_item(dett_pkg::OP_REGISTER, pick_delay(), pick_handle());
          counted++;
        end else if (r < 53) begin
          send_item(dett_pkg::OP_REMOVE, $urandom(), pick_handle());
          counted++;
        end else if (r < 96) begin
          send_item(dett_pkg::OP_TICK, $urandom(), 8'($urandom_range(0, 255)));
          counted++;
        end else begin
          send_item(dett_pkg::OP_UNUSED, $urandom(), 8'($urandom_range(0, 255)));
        end
      end
    end

    // Drain: wait for every predicted result, then twice a walk time more so
    // that a stray extra result would still be caught by the monitor.
    @(negedge clk);
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
